[hdl/rrle_pkg.sv]
// shared types, constants and parse phases for the row run-length bitmap decoder
package rrle_pkg;

    // row and width limits
    localparam int MAX_ROW_BYTES = 8192;
    localparam int MAX_ROWS      = 4096;

    // field widths
    localparam int WIDTH_W  = 14;
    localparam int COL_W    = 13;
    localparam int ROW_W    = 12;
    localparam int CNT_W    = 16;
    localparam int BYTE_W   = 8;

    // width register reset value
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(80);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_ROW_BYTES);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(1);
    localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(MAX_ROWS - 1);

    // full-row fill value
    localparam logic [BYTE_W-1:0] FULL_ROW_VALUE = 8'hFF;

    // item kinds
    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_DATA   = 1'b1;

    // configuration register index
    localparam logic REG_ROW_WIDTH = 1'b0;

    // run queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_LIT,
        PH_COUNT,
        PH_VALUE
    } phase_t;

    // coded input item
    typedef struct packed {
        logic              func;
        logic [CNT_W-1:0]  row_bytes;
        logic [BYTE_W-1:0] data_byte;
    } code_t;

    // decoded run
    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [COL_W-1:0]   column;
        logic [BYTE_W-1:0]  pixel_value;
        logic [WIDTH_W-1:0] repeat_count;
    } run_t;

    // run request from front to back, count not yet clipped
    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [WIDTH_W-1:0] column;
        logic [BYTE_W-1:0]  pixel_value;
        logic [WIDTH_W-1:0] raw_count;
    } run_req_t;

endpackage

[hdl/rrle_front.sv]
// front end: parses coded bytes and issues run requests
module rrle_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rrle_pkg::WIDTH_W-1:0]  eff_width,
    input  logic                          code_valid,
    input  rrle_pkg::code_t               code,
    input  logic                          queue_full,
    output logic                          code_stall,
    output logic                          push,
    output rrle_pkg::run_req_t            push_data
);

    rrle_pkg::phase_t                 phase_reg, phase_next;
    logic [rrle_pkg::CNT_W-1:0]       left_reg, left_next;
    logic [rrle_pkg::WIDTH_W-1:0]     col_reg, col_next;
    logic [rrle_pkg::BYTE_W-1:0]      run_reg, run_next;
    logic [rrle_pkg::BYTE_W-1:0]      fill_reg, fill_next;
    logic [rrle_pkg::ROW_W-1:0]       row_reg, row_next;

    logic                             accept;
    logic                             is_header;
    logic                             active;
    logic [rrle_pkg::CNT_W-1:0]       left_dec;
    logic                             left_last;
    logic [rrle_pkg::BYTE_W-1:0]      b;
    logic [rrle_pkg::BYTE_W-1:0]      len;
    logic [rrle_pkg::BYTE_W-1:0]      run_dec;
    logic [rrle_pkg::WIDTH_W-1:0]     adv_n;
    logic [rrle_pkg::WIDTH_W:0]       adv_sum;
    logic [rrle_pkg::WIDTH_W-1:0]     col_adv;
    logic                             col_in;
    logic                             done_idle;
    logic [rrle_pkg::ROW_W-1:0]       row_inc;

    // transfer and stall
    assign code_stall = queue_full;
    assign accept     = code_valid && !code_stall;
    assign is_header  = (code.func == rrle_pkg::FUNC_HEADER);
    assign active     = (phase_reg != rrle_pkg::PH_IDLE) && (left_reg != '0);

    // shared datapath terms
    assign b         = code.data_byte;
    assign left_dec  = left_reg - rrle_pkg::CNT_W'(1);
    assign left_last = (left_dec == '0);
    assign len       = ({8'd0, b} < left_dec) ? b : left_dec[rrle_pkg::BYTE_W-1:0];
    assign run_dec   = run_reg - rrle_pkg::BYTE_W'(1);
    assign row_inc   = (row_reg >= rrle_pkg::ROW_LAST) ? '0 : row_reg + rrle_pkg::ROW_W'(1);

    // column advance, clipped to the row width
    always_comb
    begin
        case (phase_reg)
            rrle_pkg::PH_COUNT: adv_n = {6'd0, b};
            rrle_pkg::PH_VALUE: adv_n = {6'd0, fill_reg};
            default:            adv_n = rrle_pkg::WIDTH_W'(1);
        endcase
    end

    assign adv_sum   = {1'b0, col_reg} + {1'b0, adv_n};
    assign col_adv   = (adv_sum > {1'b0, eff_width}) ? eff_width
                                                     : adv_sum[rrle_pkg::WIDTH_W-1:0];
    assign col_in    = (col_reg < eff_width);
    assign done_idle = left_last || (col_adv >= eff_width);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (is_header)
            begin
                phase_next = (code.row_bytes == '0) ? rrle_pkg::PH_IDLE : rrle_pkg::PH_HEAD;
            end
            else if (!active)
            begin
                phase_next = rrle_pkg::PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    rrle_pkg::PH_HEAD:
                    begin
                        if (left_last)
                            phase_next = rrle_pkg::PH_IDLE;
                        else if (b != '0)
                            phase_next = rrle_pkg::PH_LIT;
                        else
                            phase_next = rrle_pkg::PH_COUNT;
                    end
                    rrle_pkg::PH_LIT:
                    begin
                        if (run_dec == '0)
                            phase_next = done_idle ? rrle_pkg::PH_IDLE : rrle_pkg::PH_HEAD;
                    end
                    rrle_pkg::PH_COUNT:
                    begin
                        phase_next = left_last ? rrle_pkg::PH_IDLE : rrle_pkg::PH_VALUE;
                    end
                    rrle_pkg::PH_VALUE:
                    begin
                        phase_next = done_idle ? rrle_pkg::PH_IDLE : rrle_pkg::PH_HEAD;
                    end
                    default:
                    begin
                        phase_next = rrle_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // counters and run requests
    always_comb
    begin
        left_next = left_reg;
        col_next  = col_reg;
        run_next  = run_reg;
        fill_next = fill_reg;
        row_next  = row_reg;
        push      = 1'b0;
        push_data = '{row_index: row_reg, column: col_reg, pixel_value: b,
                      raw_count: rrle_pkg::WIDTH_W'(1)};
        if (accept)
        begin
            if (is_header)
            begin
                row_next  = row_inc;
                col_next  = '0;
                run_next  = '0;
                fill_next = '0;
                left_next = code.row_bytes;
                if (code.row_bytes == '0)
                begin
                    push      = 1'b1;
                    push_data = '{row_index: row_inc, column: '0,
                                  pixel_value: rrle_pkg::FULL_ROW_VALUE,
                                  raw_count: eff_width};
                end
            end
            else if (active)
            begin
                left_next = left_dec;
                unique case (phase_reg)
                    rrle_pkg::PH_HEAD:
                    begin
                        if (b != '0 && !left_last)
                            run_next = len;
                    end
                    rrle_pkg::PH_LIT:
                    begin
                        push     = col_in;
                        col_next = col_adv;
                        run_next = run_dec;
                    end
                    rrle_pkg::PH_COUNT:
                    begin
                        fill_next = b;
                        if (left_last)
                        begin
                            push      = (b != '0) && col_in;
                            push_data.pixel_value = '0;
                            push_data.raw_count   = {6'd0, b};
                            col_next  = col_adv;
                        end
                    end
                    rrle_pkg::PH_VALUE:
                    begin
                        push     = (fill_reg != '0) && col_in;
                        push_data.raw_count = {6'd0, fill_reg};
                        col_next = col_adv;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrle_pkg::PH_IDLE;
            left_reg  <= '0;
            col_reg   <= '0;
            run_reg   <= '0;
            fill_reg  <= '0;
            row_reg   <= '1;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            col_reg   <= col_next;
            run_reg   <= run_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
        end
    end

endmodule

[hdl/rrle_queue.sv]
// short run request queue between front and back
module rrle_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rrle_pkg::run_req_t   push_data,
    input  logic                 pop,
    output rrle_pkg::run_req_t   head,
    output logic                 empty,
    output logic                 full
);

    rrle_pkg::run_req_t               entry_reg [rrle_pkg::QUEUE_DEPTH];
    logic [rrle_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rrle_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rrle_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == rrle_pkg::QCNT_W'(rrle_pkg::QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == rrle_pkg::QPTR_W'(rrle_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + rrle_pkg::QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == rrle_pkg::QPTR_W'(rrle_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + rrle_pkg::QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + rrle_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - rrle_pkg::QCNT_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // no write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("run queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("run queue read while empty");

endmodule

[hdl/rrle_back.sv]
// back end: clips run length to the row and drives the output register
module rrle_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rrle_pkg::WIDTH_W-1:0]  eff_width,
    input  rrle_pkg::run_req_t            head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          run_valid,
    input  logic                          run_stall,
    output rrle_pkg::run_t                run
);

    logic                             out_valid_reg, out_valid_next;
    rrle_pkg::run_t                   out_reg;
    logic [rrle_pkg::WIDTH_W-1:0]     room;
    logic [rrle_pkg::WIDTH_W-1:0]     clip_count;

    // take the next request when the output register is free or draining
    assign pop = !empty && (!out_valid_reg || !run_stall);

    // clip the count to the room left in the row
    assign room       = eff_width - head.column;
    assign clip_count = (head.raw_count < room) ? head.raw_count : room;

    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (run_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg.row_index    <= head.row_index;
            out_reg.column       <= head.column[rrle_pkg::COL_W-1:0];
            out_reg.pixel_value  <= head.pixel_value;
            out_reg.repeat_count <= clip_count;
        end
    end

    assign run_valid = out_valid_reg;
    assign run       = out_reg;

    // every run is nonempty and stays inside the row
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.repeat_count != '0))
        else $error("run with zero repeat count");

    a_inside_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (({1'b0, out_reg.column} + {1'b0, out_reg.repeat_count})
                           <= {1'b0, eff_width}))
        else $error("run extends past the row width");

endmodule

[hdl/row_rle_bitmap_decoder.sv]
// top level of the row run-length bitmap decoder with its width register
// the code transfer writes the run queue, from which the output register loads the run
// throughput: one coded item per cycle while code_stall is low; the front parser updates
// its counters per item, and the two-entry run queue and output register absorb output stalls
// code_stall rises only when the run queue holds two runs
// reset: parser idle, row counter all ones, row width 80, no clearing pass
module row_rle_bitmap_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                code_valid,
    output logic                code_stall,
    input  rrle_pkg::code_t     code,
    output logic                run_valid,
    input  logic                run_stall,
    output rrle_pkg::run_t      run
);

    logic [rrle_pkg::WIDTH_W-1:0]   width_raw_reg, width_raw_next;
    logic [rrle_pkg::WIDTH_W-1:0]   eff_width_reg, eff_width_next;
    logic [rrle_pkg::WIDTH_W-1:0]   wr_width;
    logic                           cfg_write;
    logic                           push;
    rrle_pkg::run_req_t             push_data;
    logic                           pop;
    rrle_pkg::run_req_t             head;
    logic                           empty;
    logic                           full;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == rrle_pkg::REG_ROW_WIDTH);
    assign wr_width  = pwdata[rrle_pkg::WIDTH_W-1:0];
    assign prdata    = (paddr[2] == rrle_pkg::REG_ROW_WIDTH)
                       ? {{(32 - rrle_pkg::WIDTH_W){1'b0}}, width_raw_reg} : '0;

    // width register and its clamped working value
    always_comb
    begin
        width_raw_next = width_raw_reg;
        eff_width_next = eff_width_reg;
        if (cfg_write)
        begin
            width_raw_next = wr_width;
            if (wr_width < rrle_pkg::WIDTH_MIN)
                eff_width_next = rrle_pkg::WIDTH_MIN;
            else if (wr_width > rrle_pkg::WIDTH_MAX)
                eff_width_next = rrle_pkg::WIDTH_MAX;
            else
                eff_width_next = wr_width;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg <= rrle_pkg::WIDTH_RESET;
            eff_width_reg <= rrle_pkg::WIDTH_RESET;
        end
        else
        begin
            width_raw_reg <= width_raw_next;
            eff_width_reg <= eff_width_next;
        end
    end

    // parser
    rrle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_width  (eff_width_reg),
        .code_valid (code_valid),
        .code       (code),
        .queue_full (full),
        .code_stall (code_stall),
        .push       (push),
        .push_data  (push_data)
    );

    // run queue
    rrle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    // run clipping and output
    rrle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_width (eff_width_reg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run       (run)
    );

endmodule
